FILE: design/tssc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package tssc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TEMP_W  = 16;
   localparam int unsigned INDEX_W = 4;

   localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;
   localparam logic [BYTE_W-1:0] CRC_INIT      = 8'h00;

   localparam logic [INDEX_W-1:0] IDX_TEMP_LSB  = 4'd0;
   localparam logic [INDEX_W-1:0] IDX_TEMP_MSB  = 4'd1;
   localparam logic [INDEX_W-1:0] IDX_ALARM_HI  = 4'd2;
   localparam logic [INDEX_W-1:0] IDX_ALARM_LO  = 4'd3;
   localparam logic [INDEX_W-1:0] IDX_CONFIG    = 4'd4;
   localparam logic [INDEX_W-1:0] IDX_CRC_BYTE  = 4'd8;
   localparam logic [INDEX_W-1:0] IDX_DONE      = 4'd9;

   typedef struct packed {
      logic [BYTE_W-1:0] scratch_byte;
      logic              first_byte;
   } req_type;

   typedef struct packed {
      logic                     load;
      logic                     status;
      logic signed [TEMP_W-1:0] temperature;
      logic [BYTE_W-1:0]        config_byte;
      logic [BYTE_W-1:0]        alarm_high;
      logic [BYTE_W-1:0]        alarm_low;
      logic [BYTE_W-1:0]        crc_value;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] d;
      logic              fb;
      c = crc;
      d = data;
      for (int k = 0; k < BYTE_W; k++) begin
         fb = c[0] ^ d[0];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY_REFL;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/temp_sensor_scratchpad_checker.sv
// Top level of the scratchpad checker: request register, frame tracker, result register.
// Depends on tssc_pkg, tssc_frame and tssc_out.
//
// Usage:
//   Send the nine scratchpad bytes of a one-wire temperature sensor on the req_
//   channel, byte 0 flagged by req_first_byte. Bytes 0 to 7 are folded into the
//   reflected CRC-8 (x^8+x^5+x^4+1, init 0); byte 8 is compared with it and one
//   result appears on the rsp_ channel: status (1 = CRC mismatch), temperature in
//   1/16 degree C as 16-bit two's complement, config and alarm bytes, and the CRC.
//   Bytes after the ninth give nothing until the next flagged first byte.
//   Throughput: one request per cycle while no result is stalled; every request passes
//   the request register and the frame/CRC logic behind it.
//   Result path: the ninth byte passes the request register, then the result register.
//   Reset: synchronous; clears the count, CRC and stored bytes, so the first byte
//   after reset is byte 0 even without the flag, and empties both registers.
//   Stall: while rsp_ready is low a waiting result holds; one more request is
//   taken into the request register, then req_ready drops until the result goes.
`default_nettype none

module temp_sensor_scratchpad_checker
   import tssc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_scratch_byte,
   input  wire logic                 req_first_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_status,
   output logic signed [TEMP_W-1:0]  rsp_temperature,
   output logic [BYTE_W-1:0]         rsp_config_byte,
   output logic [BYTE_W-1:0]         rsp_alarm_high,
   output logic [BYTE_W-1:0]         rsp_alarm_low,
   output logic [BYTE_W-1:0]         rsp_crc_value
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    advance;
   rsp_type result;

   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff.scratch_byte <= req_scratch_byte;
         in_data_ff.first_byte   <= req_first_byte;
      end
   end

   tssc_frame u_frame (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .rsp   (result)
   );

   tssc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .rsp         (result),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .status      (rsp_status),
      .temperature (rsp_temperature),
      .config_byte (rsp_config_byte),
      .alarm_high  (rsp_alarm_high),
      .alarm_low   (rsp_alarm_low),
      .crc_value   (rsp_crc_value)
   );

endmodule

`default_nettype wire

FILE: design/tssc_frame.sv
// Frame tracker: byte count, running CRC-8 and the stored scratchpad fields.
// Depends on tssc_pkg.
`default_nettype none

module tssc_frame
   import tssc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   output rsp_type      rsp
);

   logic [INDEX_W-1:0] index_ff, index_in;
   logic [BYTE_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0]  temp_lsb_ff, temp_lsb_in;
   logic [BYTE_W-1:0]  temp_msb_ff, temp_msb_in;
   logic [BYTE_W-1:0]  upper_ff, upper_in;
   logic [BYTE_W-1:0]  lower_ff, lower_in;
   logic [BYTE_W-1:0]  cfg_ff, cfg_in;

   logic [INDEX_W-1:0] index_eff;
   logic [BYTE_W-1:0]  crc_eff;

   always_comb begin
      index_eff   = req.first_byte ? IDX_TEMP_LSB : index_ff;
      crc_eff     = req.first_byte ? CRC_INIT : crc_ff;
      index_in    = index_ff;
      crc_in      = crc_ff;
      temp_lsb_in = temp_lsb_ff;
      temp_msb_in = temp_msb_ff;
      upper_in    = upper_ff;
      lower_in    = lower_ff;
      cfg_in      = cfg_ff;
      if (step) begin
         if (index_eff < IDX_CRC_BYTE) begin
            unique case (index_eff)
               IDX_TEMP_LSB: temp_lsb_in = req.scratch_byte;
               IDX_TEMP_MSB: temp_msb_in = req.scratch_byte;
               IDX_ALARM_HI: upper_in    = req.scratch_byte;
               IDX_ALARM_LO: lower_in    = req.scratch_byte;
               IDX_CONFIG:   cfg_in      = req.scratch_byte;
               default: ;
            endcase
            crc_in   = crc8_update(crc_eff, req.scratch_byte);
            index_in = index_eff + 4'd1;
         end else if (index_eff == IDX_CRC_BYTE) begin
            crc_in   = crc_eff;
            index_in = IDX_DONE;
         end
      end
   end

   always_comb begin
      rsp.load        = step && (index_eff == IDX_CRC_BYTE);
      rsp.status      = req.scratch_byte != crc_eff;
      rsp.temperature = signed'({temp_msb_ff, temp_lsb_ff});
      rsp.config_byte = cfg_ff;
      rsp.alarm_high  = upper_ff;
      rsp.alarm_low   = lower_ff;
      rsp.crc_value   = crc_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= IDX_TEMP_LSB;
         crc_ff      <= CRC_INIT;
         temp_lsb_ff <= '0;
         temp_msb_ff <= '0;
         upper_ff    <= '0;
         lower_ff    <= '0;
         cfg_ff      <= '0;
      end else begin
         index_ff    <= index_in;
         crc_ff      <= crc_in;
         temp_lsb_ff <= temp_lsb_in;
         temp_msb_ff <= temp_msb_in;
         upper_ff    <= upper_in;
         lower_ff    <= lower_in;
         cfg_ff      <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/tssc_out.sv
// Result register: holds one finished result until the receiver takes it.
// Depends on tssc_pkg.
`default_nettype none

module tssc_out
   import tssc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rsp_type                  rsp,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic                          status,
   output logic signed [TEMP_W-1:0]      temperature,
   output logic [BYTE_W-1:0]             config_byte,
   output logic [BYTE_W-1:0]             alarm_high,
   output logic [BYTE_W-1:0]             alarm_low,
   output logic [BYTE_W-1:0]             crc_value
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      if (rsp.load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.load) begin
         data_ff <= rsp;
      end
   end

   assign out_valid   = valid_ff;
   assign status      = data_ff.status;
   assign temperature = data_ff.temperature;
   assign config_byte = data_ff.config_byte;
   assign alarm_high  = data_ff.alarm_high;
   assign alarm_low   = data_ff.alarm_low;
   assign crc_value   = data_ff.crc_value;

endmodule

`default_nettype wire

FILE: design/tssc_checker.sv
// Port-level checks on the scratchpad checker, bound to its top level.
// Depends on tssc_pkg and temp_sensor_scratchpad_checker.
`default_nettype none

module tssc_checker
   import tssc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [BYTE_W-1:0]   rsp_crc_value
);

   // a waiting result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_value))
      else $error("result dropped or changed while stalled");

   // a new result follows an accepted request through the request and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching request");

   // back-pressure only from a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side stalled without a stalled result");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind temp_sensor_scratchpad_checker tssc_checker u_tssc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_crc_value (rsp_crc_value)
);

`default_nettype wire
